[hdl/bsa_pkg.sv]
// Shared types, constants and helper functions for the bitmap slot allocator.
// Used by every module in the hdl folder; depends on nothing else.

package bsa_pkg;

    // Fixed field widths.
    localparam int GRANT_W  = 10;
    localparam int CNT_W    = 11;
    localparam int SLOT_W   = 16;
    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;
    localparam int CFG_IDX_W = 1;

    // Default pool size in 64-bit words.
    localparam int MAP_WORDS_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0] GROW_THR_RST    = CNT_W'(64);
    localparam logic [CNT_W-1:0] RELEASE_THR_RST = CNT_W'(512);

    // Request kinds.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GROW    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // One result item.
    typedef struct packed {
        logic [GRANT_W-1:0] granted_slot;
        t_status            status;
        logic [CNT_W-1:0]   used_slots;
        logic [CNT_W-1:0]   free_slots;
        logic               grow_wanted;
        logic               may_release;
    } t_result;

    // Index of the lowest set bit of a map word; zero for an empty word.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int n = WORD_W - 1; n >= 0; n--) begin
            if (w[n]) begin
                r = BIT_W'(n);
            end
        end
        return r;
    endfunction

endpackage

[hdl/bsa_map_mem.sv]
// Free bitmap storage: a synchronous single-write, single-read memory of 64-bit words.
// Per-word written flags make an unwritten word read as all ones. Depends on bsa_pkg.

module bsa_map_mem #(
    parameter int WORDS  = bsa_pkg::MAP_WORDS_DEF,
    parameter int ADDR_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [bsa_pkg::WORD_W-1:0] i_wr_data,
    output logic [bsa_pkg::WORD_W-1:0] o_rd_word
);
    import bsa_pkg::*;

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORDS-1:0]  r_written;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_written;

    // Memory array write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, with forwarding of a write to the same word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_addr == i_rd_addr) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    // Written flags: cleared by reset, so every word starts out all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr] ||
                                (i_wr_en && i_wr_addr == i_rd_addr);
            end
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_word = r_rd_written ? r_rd_data : '1;

endmodule

[hdl/bsa_out_stage.sv]
// Result register that holds one result until the consumer takes it.
// Depends on bsa_pkg for the result struct.

module bsa_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bsa_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output bsa_pkg::t_result o_result
);
    import bsa_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Valid flag: set on load, cleared when the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

endmodule

[hdl/bitmap_slot_allocator.sv]
// Top level of the bitmap slot allocator: request controller, summary bits and counters.
// Depends on bsa_pkg, bsa_map_mem and bsa_out_stage.
//
//  Channel   Direction  Handshake               Payload
//  request   in         i_valid / o_ready       i_action, i_slot_to_free
//  result    out        o_valid / i_ready       o_granted_slot .. o_may_release
//  config    in         i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// Each request is handled in S_IDLE, which picks the word and reads the bitmap memory, then in S_EXEC,
// which modifies the word, writes it back and loads the result register.
// The split follows from the registered read port of the bitmap memory.
// A full result register that is not being taken holds the request in S_EXEC.
// Reset is synchronous; all slots are free right after reset, with no clearing pass.

module bitmap_slot_allocator #(
    parameter int MAP_WORDS = bsa_pkg::MAP_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [bsa_pkg::SLOT_W-1:0]    i_slot_to_free,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bsa_pkg::GRANT_W-1:0]   o_granted_slot,
    output logic [1:0]                    o_status,
    output logic [bsa_pkg::CNT_W-1:0]     o_used_slots,
    output logic [bsa_pkg::CNT_W-1:0]     o_free_slots,
    output logic                          o_grow_wanted,
    output logic                          o_may_release,
    input  logic                          i_cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsa_pkg::CNT_W-1:0]     i_cfg_data
);
    import bsa_pkg::*;

    localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SLOT_COUNT = MAP_WORDS * WORD_W;
    localparam int USED_W     = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W      = (USED_W > CNT_W) ? USED_W : CNT_W;
    localparam int IDX_W      = ADDR_W + BIT_W;

    t_state              r_state, n_state;
    logic                r_action;
    logic [SLOT_W-1:0]   r_slot;
    logic [ADDR_W-1:0]   r_word;
    logic                r_full;
    logic                r_range;
    logic [USED_W-1:0]   r_used, n_used;
    logic [MAP_WORDS-1:0] r_summary;
    logic [CNT_W-1:0]    r_grow_thr;
    logic [CNT_W-1:0]    r_rel_thr;

    logic                accept;
    logic                proceed;
    logic                out_can_load;
    logic [ADDR_W-1:0]   first_word;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   map_word;
    logic [BIT_W-1:0]    bit_idx;
    logic [WORD_W-1:0]   bit_mask;
    logic [WORD_W-1:0]   new_word;
    logic                op_ok;
    logic                wr_en;
    logic [IDX_W-1:0]    grant_idx;
    logic [USED_W-1:0]   free_cnt;
    t_status             status;
    t_result             result;
    t_result             out_result;

    // Lowest word that still holds a free slot.
    always_comb begin
        first_word = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--) begin
            if (r_summary[i]) begin
                first_word = ADDR_W'(i);
            end
        end
    end

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign rd_addr = (i_action == ACT_FREE) ? i_slot_to_free[BIT_W +: ADDR_W] : first_word;

    // Controller state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: read in S_IDLE, finish in S_EXEC once the result register can load.
    always_comb begin
        n_state = r_state;
        proceed = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_can_load) begin
                    proceed = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Request capture at acceptance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_slot   <= i_slot_to_free;
            r_word   <= rd_addr;
            r_full   <= (i_action == ACT_ALLOC) && (r_summary == '0);
            r_range  <= (i_action == ACT_FREE) &&
                        ({1'b0, i_slot_to_free} >= (SLOT_W + 1)'(SLOT_COUNT));
        end
    end

    bsa_map_mem #(
        .WORDS  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_word),
        .i_wr_data (new_word),
        .o_rd_word (map_word)
    );

    // Modify the word read from the bitmap and decide the status.
    always_comb begin
        bit_idx  = (r_action == ACT_ALLOC) ? lowest_set(map_word) : r_slot[BIT_W-1:0];
        bit_mask = WORD_W'(1) << bit_idx;
        new_word = (r_action == ACT_ALLOC) ? (map_word & ~bit_mask) : (map_word | bit_mask);
        op_ok    = 1'b0;
        status   = ST_OK;
        n_used   = r_used;
        if (r_action == ACT_ALLOC) begin
            if (r_full) begin
                status = ST_FULL;
            end else begin
                op_ok  = 1'b1;
                n_used = r_used + USED_W'(1);
            end
        end else if (r_range) begin
            status = ST_RANGE;
        end else if ((map_word & bit_mask) != '0) begin
            status = ST_NOT_ALLOC;
        end else begin
            op_ok = 1'b1;
            if (r_used != '0) begin
                n_used = r_used - USED_W'(1);
            end
        end
    end

    assign wr_en     = proceed && op_ok;
    assign grant_idx = {r_word, bit_idx};
    assign free_cnt  = USED_W'(SLOT_COUNT) - n_used;

    // Result item with counts and advisory flags after this request.
    always_comb begin
        result.granted_slot = (r_action == ACT_ALLOC && op_ok) ? GRANT_W'(grant_idx) : '0;
        result.status       = status;
        result.used_slots   = CNT_W'(n_used);
        result.free_slots   = CNT_W'(free_cnt);
        result.grow_wanted  = CMP_W'(free_cnt) < CMP_W'(r_grow_thr);
        result.may_release  = (n_used == '0) && (CMP_W'(free_cnt) > CMP_W'(r_rel_thr));
    end

    // Summary bits and used count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summary <= '1;
            r_used    <= '0;
        end else if (wr_en) begin
            r_summary[r_word] <= (new_word != '0);
            r_used            <= n_used;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grow_thr <= GROW_THR_RST;
            r_rel_thr  <= RELEASE_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GROW:    r_grow_thr <= i_cfg_data;
                CFG_RELEASE: r_rel_thr  <= i_cfg_data;
                default:     r_grow_thr <= r_grow_thr;
            endcase
        end
    end

    bsa_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (proceed),
        .i_result   (result),
        .o_can_load (out_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_granted_slot = out_result.granted_slot;
    assign o_status       = out_result.status;
    assign o_used_slots   = out_result.used_slots;
    assign o_free_slots   = out_result.free_slots;
    assign o_grow_wanted  = out_result.grow_wanted;
    assign o_may_release  = out_result.may_release;

`ifndef SYNTHESIS
    // An accepted request always moves on to the modify cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_EXEC)
        else $error("request accepted but controller not in modify cycle");

    // The used count never exceeds the pool size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(SLOT_COUNT))
        else $error("used count exceeds pool size");

    // A granted allocation clears exactly one free bit in the word.
    a_alloc_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_action == ACT_ALLOC) |->
            ($countones(new_word) + 1 == $countones(map_word)))
        else $error("allocation did not clear exactly one bit");

    // A new result only appears after a modify cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_EXEC)
        else $error("result appeared without a modify cycle");
`endif

endmodule
